/* src/laser_scan_grid_marker_defines.svh */
// Assertion macros shared by the laser scan grid marker RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef LASER_SCAN_GRID_MARKER_DEFINES_SVH
`define LASER_SCAN_GRID_MARKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSGM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSGM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lsgm_pkg.sv */
// Shared types, constants and the CORDIC arctangent table of the grid marker.
// Depends on nothing; imported by every module of the block.
package lsgm_pkg;

   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;
   localparam int MAX_BEAMS   = 2048;
   localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W      = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

   localparam int CORDIC_STEPS = 14;
   localparam int CORDIC_X0    = 19898;
   localparam int QUARTER      = 16384;
   localparam int CQ_W         = 18;   // cordic x/y/z width
   localparam int PROD_W       = 35;   // 17-bit range times 18-bit cos/sin
   localparam int NUM_W        = 21;   // coordinate in mm relative to origin
   localparam int DIV_W        = 20;   // dividend bits fed to the divider
   localparam int DIV_CNT_W    = $clog2(DIV_W);

   localparam logic [15:0] MAX_RANGE_RST = 16'd6000;
   localparam logic [9:0]  CELL_SIZE_RST = 10'd50;
   localparam logic [15:0] ORIGIN_RST    = 16'hEC78;   // -5000
   localparam logic [7:0]  MARK_RST      = 8'd100;
   localparam logic [7:0]  UNKNOWN_CELL  = 8'hFF;      // -1

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_BEAM  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_START_ANGLE = 3'd0,
      REG_ANGLE_STEP  = 3'd1,
      REG_MIN_RANGE   = 3'd2,
      REG_MAX_RANGE   = 3'd3,
      REG_CELL_SIZE   = 3'd4,
      REG_ORIGIN_X    = 3'd5,
      REG_ORIGIN_Y    = 3'd6,
      REG_MARK_VALUE  = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_CSTART,
      ST_CWAIT,
      ST_MULT,
      ST_SUB,
      ST_DIV,
      ST_PLACE,
      ST_READ,
      ST_READ_CAP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;          // latch request word, zero the result
      logic angle;         // form beam angle
      logic cordic_start;
      logic mult;
      logic sub;           // subtract origin, arm divider
      logic div_step;
      logic place;         // bounds check and mark
      logic read;
      logic read_cap;
      logic clear_step;
   } ctrl_type;

   typedef struct packed {
      cmd_type command;
      logic    reject;
      logic    cordic_done;
      logic    div_last;
      logic    clear_last;
   } status_type;

   function automatic logic signed [CQ_W-1:0] atan_units(input logic [3:0] idx);
      logic signed [CQ_W-1:0] v;
      case (idx)
         4'd0:    v = 18'sd8192;
         4'd1:    v = 18'sd4836;
         4'd2:    v = 18'sd2555;
         4'd3:    v = 18'sd1297;
         4'd4:    v = 18'sd651;
         4'd5:    v = 18'sd326;
         4'd6:    v = 18'sd163;
         4'd7:    v = 18'sd81;
         4'd8:    v = 18'sd41;
         4'd9:    v = 18'sd20;
         4'd10:   v = 18'sd10;
         4'd11:   v = 18'sd5;
         4'd12:   v = 18'sd3;
         4'd13:   v = 18'sd1;
         default: v = 18'sd0;
      endcase
      return v;
   endfunction

endpackage

/* src/lsgm_cordic.sv */
// Iterative CORDIC rotation: one micro-rotation per cycle, quadrant fold first.
// Depends on lsgm_pkg.
module lsgm_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [15:0]                        angle,
   output logic                               done,
   output logic signed [lsgm_pkg::CQ_W-1:0]   cos_q,
   output logic signed [lsgm_pkg::CQ_W-1:0]   sin_q
);
   import lsgm_pkg::*;

   logic signed [CQ_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [3:0]             step_ff, step_in;
   logic                   active_ff, active_in, done_ff, done_in;
   logic                   turn_pos_ff, turn_pos_in, turn_neg_ff, turn_neg_in;
   logic signed [CQ_W-1:0] a_ext, dx, dy, at;

   always_comb begin
      a_ext       = CQ_W'($signed(angle));
      dx          = y_ff >>> step_ff;
      dy          = x_ff >>> step_ff;
      at          = atan_units(step_ff);
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      step_in     = step_ff;
      active_in   = active_ff;
      done_in     = 1'b0;
      turn_pos_in = turn_pos_ff;
      turn_neg_in = turn_neg_ff;
      if (start) begin
         // fold into the range the rotation converges on
         x_in        = CQ_W'(CORDIC_X0);
         y_in        = '0;
         step_in     = '0;
         active_in   = 1'b1;
         turn_pos_in = a_ext > CQ_W'(QUARTER);
         turn_neg_in = a_ext < -CQ_W'(QUARTER);
         if (a_ext > CQ_W'(QUARTER)) begin
            z_in = a_ext - CQ_W'(QUARTER);
         end else if (a_ext < -CQ_W'(QUARTER)) begin
            z_in = a_ext + CQ_W'(QUARTER);
         end else begin
            z_in = a_ext;
         end
      end else if (active_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(CORDIC_STEPS - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      step_ff     <= step_in;
      turn_pos_ff <= turn_pos_in;
      turn_neg_ff <= turn_neg_in;
   end

   always_comb begin
      if (turn_pos_ff) begin
         cos_q = -y_ff;
         sin_q = x_ff;
      end else if (turn_neg_ff) begin
         cos_q = y_ff;
         sin_q = -x_ff;
      end else begin
         cos_q = x_ff;
         sin_q = y_ff;
      end
   end

   assign done = done_ff;

endmodule

/* src/lsgm_datapath.sv */
// Datapath: request and config registers, CORDIC, scaling, divider, grid memory.
// Depends on lsgm_pkg and lsgm_cordic.
module lsgm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  lsgm_pkg::ctrl_type    ctrl,
   output lsgm_pkg::status_type  status,
   input  logic [1:0]            req_command,
   input  logic [10:0]           req_beam_index,
   input  logic [15:0]           req_range_mm,
   input  logic                  req_range_finite,
   input  logic [15:0]           req_read_address,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_data,
   output logic signed [7:0]     rsp_cell_value,
   output logic                  rsp_beam_marked,
   output logic [15:0]           rsp_marked_address
);
   import lsgm_pkg::*;

   // configuration
   logic [15:0] start_angle_ff, angle_step_ff, min_range_ff, max_range_ff;
   logic [15:0] origin_x_ff, origin_y_ff;
   logic [9:0]  cell_size_ff;
   logic [7:0]  mark_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff  <= '0;
         min_range_ff   <= '0;
         max_range_ff   <= MAX_RANGE_RST;
         cell_size_ff   <= CELL_SIZE_RST;
         origin_x_ff    <= ORIGIN_RST;
         origin_y_ff    <= ORIGIN_RST;
         mark_ff        <= MARK_RST;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_START_ANGLE: start_angle_ff <= csr_data;
            REG_ANGLE_STEP:  angle_step_ff  <= csr_data;
            REG_MIN_RANGE:   min_range_ff   <= csr_data;
            REG_MAX_RANGE:   max_range_ff   <= csr_data;
            REG_CELL_SIZE:   cell_size_ff   <= csr_data[9:0];
            REG_ORIGIN_X:    origin_x_ff    <= csr_data;
            REG_ORIGIN_Y:    origin_y_ff    <= csr_data;
            REG_MARK_VALUE:  mark_ff        <= csr_data[7:0];
            default:         mark_ff        <= mark_ff;
         endcase
      end
   end

   // request word
   logic [1:0]  command_ff;
   logic [10:0] beam_ff;
   logic [15:0] range_ff, raddr_ff;
   logic        finite_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         command_ff <= req_command;
         beam_ff    <= req_beam_index;
         range_ff   <= req_range_mm;
         finite_ff  <= req_range_finite;
         raddr_ff   <= req_read_address;
      end
   end

   // angle and CORDIC
   logic [15:0]            angle_ff;
   logic [26:0]            beam_prod;
   logic                   cordic_done;
   logic signed [CQ_W-1:0] cos_q, sin_q;

   assign beam_prod = 27'(beam_ff) * 27'(angle_step_ff);

   always_ff @(posedge clock) begin
      if (ctrl.angle) begin
         angle_ff <= start_angle_ff + beam_prod[15:0];
      end
   end

   lsgm_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (ctrl.cordic_start),
      .angle (angle_ff),
      .done  (cordic_done),
      .cos_q (cos_q),
      .sin_q (sin_q)
   );

   // scale by range
   logic signed [16:0]       rng_s;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, sh_x, sh_y;

   assign rng_s = $signed({1'b0, range_ff});

   always_ff @(posedge clock) begin
      if (ctrl.mult) begin
         prod_x_ff <= PROD_W'(rng_s) * PROD_W'(cos_q);
         prod_y_ff <= PROD_W'(rng_s) * PROD_W'(sin_q);
      end
   end

   // floor(prod / 32768) - origin, then floor-divide by the cell size
   logic signed [NUM_W-1:0] nx, ny;
   logic                    neg_x_ff, neg_y_ff;
   logic [DIV_W-1:0]        quo_x_ff, quo_y_ff, quo_x_in, quo_y_in;
   logic [9:0]              rem_x_ff, rem_y_ff, rem_x_in, rem_y_in, divisor;
   logic [10:0]             sh_rx, sh_ry;
   logic [DIV_CNT_W-1:0]    div_cnt_ff;

   assign sh_x    = prod_x_ff >>> 15;
   assign sh_y    = prod_y_ff >>> 15;
   assign nx      = sh_x[NUM_W-1:0] - NUM_W'($signed(origin_x_ff));
   assign ny      = sh_y[NUM_W-1:0] - NUM_W'($signed(origin_y_ff));
   assign divisor = (cell_size_ff == '0) ? 10'd1 : cell_size_ff;
   assign sh_rx   = {rem_x_ff, quo_x_ff[DIV_W-1]};
   assign sh_ry   = {rem_y_ff, quo_y_ff[DIV_W-1]};

   always_comb begin
      // one restoring step on each axis
      if (sh_rx >= {1'b0, divisor}) begin
         rem_x_in = 10'(sh_rx - {1'b0, divisor});
         quo_x_in = {quo_x_ff[DIV_W-2:0], 1'b1};
      end else begin
         rem_x_in = sh_rx[9:0];
         quo_x_in = {quo_x_ff[DIV_W-2:0], 1'b0};
      end
      if (sh_ry >= {1'b0, divisor}) begin
         rem_y_in = 10'(sh_ry - {1'b0, divisor});
         quo_y_in = {quo_y_ff[DIV_W-2:0], 1'b1};
      end else begin
         rem_y_in = sh_ry[9:0];
         quo_y_in = {quo_y_ff[DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sub) begin
         neg_x_ff   <= nx[NUM_W-1];
         neg_y_ff   <= ny[NUM_W-1];
         quo_x_ff   <= nx[DIV_W-1:0];
         quo_y_ff   <= ny[DIV_W-1:0];
         rem_x_ff   <= '0;
         rem_y_ff   <= '0;
         div_cnt_ff <= '0;
      end else if (ctrl.div_step) begin
         quo_x_ff   <= quo_x_in;
         quo_y_ff   <= quo_y_in;
         rem_x_ff   <= rem_x_in;
         rem_y_ff   <= rem_y_in;
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // placement
   logic        hit;
   logic [31:0] idx;

   assign hit = !neg_x_ff && !neg_y_ff && (32'(quo_x_ff) < 32'(GRID_WIDTH))
                && (32'(quo_y_ff) < 32'(GRID_HEIGHT));
   assign idx = 32'(quo_y_ff) * 32'(GRID_WIDTH) + 32'(quo_x_ff);

   // grid memory and clearing sweep
   logic [7:0]        occ_mem [GRID_CELLS];
   logic [7:0]        rd_data_ff;
   logic              raddr_ok_ff;
   logic [ADDR_W-1:0] clear_ptr_ff, wr_addr;
   logic [7:0]        wr_data;
   logic              wr_en;

   assign wr_en   = ctrl.clear_step || (ctrl.place && hit);
   assign wr_addr = ctrl.clear_step ? clear_ptr_ff : ADDR_W'(idx);
   assign wr_data = ctrl.clear_step ? UNKNOWN_CELL : mark_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         occ_mem[wr_addr] <= wr_data;
      end
      if (ctrl.read) begin
         rd_data_ff  <= occ_mem[ADDR_W'(raddr_ff)];
         raddr_ok_ff <= 32'(raddr_ff) < 32'(GRID_CELLS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ptr_ff <= '0;
      end else if (ctrl.clear_step) begin
         clear_ptr_ff <= status.clear_last ? '0 : clear_ptr_ff + 1'b1;
      end
   end

   // result word
   logic [7:0]  cell_ff;
   logic        marked_ff;
   logic [15:0] maddr_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cell_ff   <= '0;
         marked_ff <= 1'b0;
         maddr_ff  <= '0;
      end else if (ctrl.place) begin
         marked_ff <= hit;
         maddr_ff  <= hit ? idx[15:0] : 16'd0;
      end else if (ctrl.read_cap) begin
         cell_ff <= raddr_ok_ff ? rd_data_ff : 8'd0;
      end
   end

   assign rsp_cell_value     = $signed(cell_ff);
   assign rsp_beam_marked    = marked_ff;
   assign rsp_marked_address = maddr_ff;

   assign status.command     = cmd_type'(command_ff);
   assign status.reject      = !finite_ff || (range_ff < min_range_ff)
                               || (range_ff > max_range_ff)
                               || (32'(beam_ff) >= 32'(MAX_BEAMS));
   assign status.cordic_done = cordic_done;
   assign status.div_last    = div_cnt_ff == DIV_CNT_W'(DIV_W - 1);
   assign status.clear_last  = 32'(clear_ptr_ff) == 32'(GRID_CELLS - 1);

endmodule

/* src/lsgm_ctrl.sv */
// Controller state machine: sequences clear sweeps, beams and reads.
// Depends on lsgm_pkg and laser_scan_grid_marker_defines.svh.
`include "laser_scan_grid_marker_defines.svh"
module lsgm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   input  lsgm_pkg::status_type  status,
   output lsgm_pkg::ctrl_type    ctrl
);
   import lsgm_pkg::*;

   state_type state_ff, state_in;
   logic      clear_rsp_ff, clear_rsp_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clear_rsp_in = clear_rsp_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = clear_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.command)
               CMD_CLEAR: begin
                  state_in     = ST_CLEAR;
                  clear_rsp_in = 1'b1;
               end
               CMD_BEAM: state_in = status.reject ? ST_RESP : ST_CSTART;
               CMD_READ: state_in = ST_READ;
               default:  state_in = ST_RESP;
            endcase
         end
         ST_CSTART:   state_in = ST_CWAIT;
         ST_CWAIT:    state_in = status.cordic_done ? ST_MULT : ST_CWAIT;
         ST_MULT:     state_in = ST_SUB;
         ST_SUB:      state_in = ST_DIV;
         ST_DIV:      state_in = status.div_last ? ST_PLACE : ST_DIV;
         ST_PLACE:    state_in = ST_RESP;
         ST_READ:     state_in = ST_READ_CAP;
         ST_READ_CAP: state_in = ST_RESP;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl              = '0;
      ctrl.load         = accept;
      ctrl.angle        = state_ff == ST_DISPATCH;
      ctrl.cordic_start = state_ff == ST_CSTART;
      ctrl.mult         = state_ff == ST_MULT;
      ctrl.sub          = state_ff == ST_SUB;
      ctrl.div_step     = state_ff == ST_DIV;
      ctrl.place        = state_ff == ST_PLACE;
      ctrl.read         = state_ff == ST_READ;
      ctrl.read_cap     = state_ff == ST_READ_CAP;
      ctrl.clear_step   = state_ff == ST_CLEAR;
      busy              = state_ff != ST_IDLE;
      rsp_valid         = state_ff == ST_RESP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_rsp_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_rsp_ff <= (state_ff == ST_IDLE) ? 1'b0 : clear_rsp_in;
      end
   end

   `LSGM_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_valid, "accepted word must go busy without a result")
   `LSGM_ASSERT_NEXT(a_strobe_once, clock, reset, rsp_valid, !rsp_valid && !busy, "result strobe must last one cycle")
   `LSGM_ASSERT_NOW(a_one_write_src, clock, reset, ctrl.clear_step, !ctrl.place && !ctrl.read, "clear sweep overlaps another memory access")
   `LSGM_ASSERT_NEXT(a_div_exit, clock, reset, (state_ff == ST_DIV) && status.div_last, ctrl.place, "divider finish must lead to placement")

endmodule

/* src/laser_scan_grid_marker.sv */
// Top level of the laser scan grid marker: controller plus datapath.
// Depends on lsgm_pkg, lsgm_ctrl and lsgm_datapath.
//
// Marks beam end points in a 256 x 256 grid of signed bytes (-1 = unknown).
// Issue a word with start while busy is low. Each word gives exactly one
// result, shown for a single cycle with rsp_valid; the receiver cannot hold
// it, so capture it on that edge. After reset the grid is swept one cell per
// cycle, with busy high, before the first word is taken. A clear command
// runs the same sweep: dispatch, the sweep, then the result. A beam passes
// through dispatch, 14 CORDIC micro-rotations in one shared rotator, a
// multiply, the origin subtract and 20 steps of a bit-per-cycle divider by
// the cell size, then the write and the result. A read goes through dispatch,
// the registered memory read port and the result; rejected beams and the
// unused command go from dispatch straight to the result.
// Write configuration registers only while busy is low; csr_ready is always
// high.
module laser_scan_grid_marker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_command,
   input  logic [10:0]       req_beam_index,
   input  logic [15:0]       req_range_mm,
   input  logic              req_range_finite,
   input  logic [15:0]       req_read_address,
   output logic              rsp_valid,
   output logic signed [7:0] rsp_cell_value,
   output logic              rsp_beam_marked,
   output logic [15:0]       rsp_marked_address,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import lsgm_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   // config words are always taken
   assign csr_ready = 1'b1;

   lsgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   lsgm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .req_command        (req_command),
      .req_beam_index     (req_beam_index),
      .req_range_mm       (req_range_mm),
      .req_range_finite   (req_range_finite),
      .req_read_address   (req_read_address),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_cell_value     (rsp_cell_value),
      .rsp_beam_marked    (rsp_beam_marked),
      .rsp_marked_address (rsp_marked_address)
   );

endmodule
